[sv/bicubic_image_gradient_macros.svh]
// ----------------------------------------------------------------------------
// bicubic image gradient assertion macros
// shared property wrappers, clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef BICUBIC_IMAGE_GRADIENT_MACROS_SVH
`define BICUBIC_IMAGE_GRADIENT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true outside reset
`define BIG_ASSERT_NEVER(lbl, expr, msg) \
  `BIG_ASSERT(lbl, !(expr), msg)

`endif

[sv/big_pkg.sv]
// ----------------------------------------------------------------------------
// big_pkg
// sizes, field layout, register indexes and shared types of the gradient block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package big_pkg;

  // image store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 16;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CW    = (XW > YW) ? XW : YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // fixed point
  localparam int FRAC = 16;
  localparam int FW   = CW + FRAC;
  localparam int OPW  = PIXEL_BITS + 32;
  localparam int PW   = OPW + FRAC + 1;

  // field widths
  localparam int ADDR_W    = 20;
  localparam int VALUE_W   = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int GRAD_W    = 32;

  // input tdata layout
  localparam int ADDR_LO  = 0;
  localparam int VALUE_LO = ADDR_LO + ADDR_W;
  localparam int QX_LO    = VALUE_LO + VALUE_W;
  localparam int QY_LO    = QX_LO + COORD_W;
  localparam int IDATA_W  = ((QY_LO + COORD_W + 7) / 8) * 8;
  localparam int ODATA_W  = 2 * GRAD_W;

  // request kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  // request to the shared multiplier
  typedef struct packed {
    logic                  en;
    logic signed [OPW-1:0] a;
    logic [FRAC-1:0]       b;
  } mul_req_t;

endpackage

[sv/big_mul.sv]
// ----------------------------------------------------------------------------
// big_mul
// shared signed 48-bit by unsigned 16-bit multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module big_mul (
  input  logic                                clk_i,
  input  big_pkg::mul_req_t                   req_i,
  output logic signed [big_pkg::PW-1:0]       prod_o
);
  import big_pkg::*;

  logic signed [PW-1:0] prod_q;

  // product holds when no request is issued
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= $signed(req_i.a) * $signed({1'b0, req_i.b});
    end
  end

  assign prod_o = prod_q;

endmodule

[sv/bicubic_image_gradient.sv]
// ----------------------------------------------------------------------------
// bicubic_image_gradient
// catmull-rom bicubic gradient of a stored image at a q16.16 domain point
// ----------------------------------------------------------------------------
// The block holds an image of MAX_WIDTH x MAX_HEIGHT pixels in a memory with one
// write and one read port that is filled by pixel write requests (tuser low), one
// per cycle while no query is in progress. A query request (tuser high) maps the
// point to pixel space, reads a 4x4 stencil with edge clamping and returns gain
// times the bicubic gradient, y negated, both saturated to signed q16.16. All
// multiplications run through one shared 48x16 multiplier under a small sequencer,
// which maps the point, then for each of the four stencil rows issues the memory
// reads and runs the row spline, then runs the column splines and the gain scaling.
// The next request is taken only once the result is in the output register. The
// store has no reset: every pixel read by a query must have been written before.
// The user must write configuration only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "bicubic_image_gradient_macros.svh"

module bicubic_image_gradient (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_addr, pixel_value, query_x, query_y, zero pad
  input  logic [big_pkg::IDATA_W-1:0]       s_axis_tdata,
  // opcode
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // grad_x, grad_y
  output logic [big_pkg::ODATA_W-1:0]       m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [big_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [big_pkg::CFG_W-1:0]         cfg_data_i
);
  import big_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MX0  = 5'd1;   // x offset times low pitch half
  localparam logic [4:0] ST_MX1  = 5'd2;   // x offset times high pitch half
  localparam logic [4:0] ST_MY0  = 5'd3;
  localparam logic [4:0] ST_MY1  = 5'd4;
  localparam logic [4:0] ST_MD0  = 5'd5;
  localparam logic [4:0] ST_MD1  = 5'd6;   // y coordinate clamped
  localparam logic [4:0] ST_RD   = 5'd7;   // stencil row reads
  localparam logic [4:0] ST_CF   = 5'd8;   // spline coefficients
  localparam logic [4:0] ST_C1   = 5'd9;
  localparam logic [4:0] ST_C2   = 5'd10;
  localparam logic [4:0] ST_C3   = 5'd11;
  localparam logic [4:0] ST_C4   = 5'd12;
  localparam logic [4:0] ST_C5   = 5'd13;
  localparam logic [4:0] ST_C6   = 5'd14;
  localparam logic [4:0] ST_G0   = 5'd15;  // gain scaling
  localparam logic [4:0] ST_G1   = 5'd16;
  localparam logic [4:0] ST_G2   = 5'd17;
  localparam logic [4:0] ST_G3   = 5'd18;
  localparam logic [4:0] ST_G4   = 5'd19;  // results to the output register

  // spline passes
  localparam logic [1:0] PASS_ROW = 2'd0;  // along x over one stencil row
  localparam logic [1:0] PASS_GX  = 2'd1;  // value along y of row derivatives
  localparam logic [1:0] PASS_GY  = 2'd2;  // derivative along y of row values

  // configuration
  logic signed [CFG_W-1:0] left_q, top_q;
  logic [CFG_W-1:0]        inv_q, gain_q;
  logic [SIZE_W-1:0]       iw_q, ih_q;

  // sequencer
  logic [4:0]     state_q;
  logic [2:0]     cnt_q;
  logic [1:0]     row_q;
  logic [1:0]     pass_q;

  // mapping
  logic signed [COORD_W:0] dxf_q, dyf_q;
  logic [PW-1:0]           plo_q, sum_q;
  logic [FW-1:0]           fx_q, fy_q;

  // stencil samples and spline state
  logic [PIXEL_BITS-1:0]   mem_q [DEPTH];
  logic [PIXEL_BITS-1:0]   rdata_q;
  logic [PIXEL_BITS-1:0]   smp_q [4];
  logic signed [OPW-1:0]   rv_q [4];
  logic signed [OPW-1:0]   rd_q [4];
  logic signed [OPW-1:0]   ca_q, cb_q, cc3_q, cb2_q, cx_q, cmid_q;
  logic signed [OPW-1:0]   accv_q, accd_q;
  logic signed [OPW-1:0]   gx_q, gy_q;
  logic signed [PW-1:0]    hi_q;
  logic [GRAD_W-1:0]       ox_q;

  // output register
  logic                    ovalid_q;
  logic [ODATA_W-1:0]      odata_q;

  // shared multiplier
  mul_req_t                req;
  logic signed [PW-1:0]    prod;

  big_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (req),
    .prod_o (prod)
  );

  // pixel index of the last column and row in use
  function automatic logic [CW-1:0] size_lim(input logic [SIZE_W-1:0] s, input int mx);
    logic [CW-1:0] r;
    if (s == '0) begin
      r = '0;
    end else if (int'(s) > mx) begin
      r = CW'(mx - 1);
    end else begin
      r = CW'(s - 1'b1);
    end
    return r;
  endfunction

  // stencil neighbor k of c, clamped to the image
  function automatic logic [CW-1:0] tap(input logic [CW-1:0] c, input logic [CW-1:0] lim,
                                        input logic [1:0] k);
    logic [CW:0]   s;
    logic [CW-1:0] r;
    s = {1'b0, c} + (CW+1)'(k - 2'd1);
    case (k)
      2'd0: r = (c == '0) ? '0 : c - 1'b1;
      2'd1: r = c;
      default: r = (s > {1'b0, lim}) ? lim : s[CW-1:0];
    endcase
    return r;
  endfunction

  logic [CW-1:0] wlim, hlim, xi, yi, lim_sel, col_idx, row_idx;
  logic [AW-1:0] rd_addr;
  logic          s_fire, m_fire, out_free;

  assign wlim     = size_lim(iw_q, MAX_WIDTH);
  assign hlim     = size_lim(ih_q, MAX_HEIGHT);
  assign xi       = fx_q[FW-1:FRAC];
  assign yi       = fy_q[FW-1:FRAC];
  assign col_idx  = tap(xi, wlim, cnt_q[1:0]);
  assign row_idx  = tap(yi, hlim, row_q);
  assign rd_addr  = AW'(row_idx) * AW'(MAX_WIDTH) + AW'(col_idx);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = ovalid_q && m_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      top_q  <= '0;
      inv_q  <= CFG_W'(65536);
      gain_q <= CFG_W'(65536);
      iw_q   <= SIZE_W'(1024);
      ih_q   <= SIZE_W'(1024);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEFT_EDGE:    left_q <= cfg_data_i;
        REG_TOP_EDGE:     top_q  <= cfg_data_i;
        REG_INV_PITCH:    inv_q  <= cfg_data_i;
        REG_GAIN:         gain_q <= cfg_data_i;
        REG_IMAGE_WIDTH:  iw_q   <= cfg_data_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: ih_q   <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // image store: one write port for pixel requests, one registered read
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser == OP_WRITE &&
        32'(s_axis_tdata[ADDR_LO +: ADDR_W]) < 32'(DEPTH)) begin
      mem_q[AW'(s_axis_tdata[ADDR_LO +: ADDR_W])] <=
        PIXEL_BITS'(s_axis_tdata[VALUE_LO +: VALUE_W]);
    end
    rdata_q <= mem_q[rd_addr];
  end

  // multiplier operand selection
  logic [FRAC-1:0] t_sel;
  assign t_sel = (pass_q == PASS_ROW) ? fx_q[FRAC-1:0] : fy_q[FRAC-1:0];

  always_comb begin
    req.en = 1'b1;
    req.a  = '0;
    req.b  = '0;
    case (state_q)
      ST_MX0: begin req.a = OPW'(dxf_q);  req.b = inv_q[FRAC-1:0];       end
      ST_MX1: begin req.a = OPW'(dxf_q);  req.b = inv_q[CFG_W-1:FRAC];   end
      ST_MY0: begin req.a = OPW'(dyf_q);  req.b = inv_q[FRAC-1:0];       end
      ST_MY1: begin req.a = OPW'(dyf_q);  req.b = inv_q[CFG_W-1:FRAC];   end
      ST_C1:  begin req.a = cx_q;         req.b = t_sel;                 end
      ST_C2:  begin req.a = cc3_q;        req.b = t_sel;                 end
      ST_C3:  begin req.a = accv_q;       req.b = t_sel;                 end
      ST_C4:  begin req.a = accd_q;       req.b = t_sel;                 end
      ST_C5:  begin req.a = accv_q;       req.b = t_sel;                 end
      ST_G0:  begin req.a = gx_q;         req.b = gain_q[CFG_W-1:FRAC];  end
      ST_G1:  begin req.a = gx_q;         req.b = gain_q[FRAC-1:0];      end
      ST_G2:  begin req.a = gy_q;         req.b = gain_q[CFG_W-1:FRAC];  end
      ST_G3:  begin req.a = gy_q;         req.b = gain_q[FRAC-1:0];      end
      default: req.en = 1'b0;
    endcase
  end

  // coordinate clamp: zero left of or above the image, last pixel beyond it
  logic          map_pos;
  logic [FW-1:0] map_coord;
  assign lim_sel = (state_q == ST_MY1) ? wlim : hlim;
  assign map_pos = (state_q == ST_MY1) ? (!dxf_q[COORD_W] && dxf_q != '0)
                                       : (!dyf_q[COORD_W] && dyf_q != '0);
  always_comb begin
    if (!map_pos || sum_q <= PW'(32768)) begin
      map_coord = '0;
    end else if (sum_q > PW'({lim_sel, 1'b1, 15'b0})) begin
      map_coord = {lim_sel, 16'b0};
    end else begin
      map_coord = FW'(sum_q - PW'(32768));
    end
  end

  // spline coefficients of the selected four points
  logic signed [OPW-1:0] sp, sc, sn, sa, co_c;
  always_comb begin
    case (pass_q)
      PASS_ROW: begin
        sp = OPW'(smp_q[0]); sc = OPW'(smp_q[1]);
        sn = OPW'(smp_q[2]); sa = OPW'(smp_q[3]);
      end
      PASS_GX: begin
        sp = rd_q[0]; sc = rd_q[1]; sn = rd_q[2]; sa = rd_q[3];
      end
      default: begin
        sp = rv_q[0]; sc = rv_q[1]; sn = rv_q[2]; sa = rv_q[3];
      end
    endcase
    co_c = sc + (sc <<< 1) - sp - sn - (sn <<< 1) + sa;
  end

  // spline results; row pass keeps 16 extra fraction bits
  logic signed [PW-1:0] res_v, res_d, dq;
  always_comb begin
    dq = prod + (PW'(ca_q) <<< FRAC);
    if (pass_q == PASS_ROW) begin
      res_v = (PW'(cmid_q) <<< FRAC) + (prod >>> 1);
      res_d = dq >>> 1;
    end else begin
      res_v = PW'(cmid_q) + (prod >>> (FRAC + 1));
      res_d = dq >>> (FRAC + 1);
    end
  end

  // gain scaling: floor(gain * g / 2^24) from the two gain halves, saturated
  logic signed [PW:0]   lo_sum, sv;
  logic [GRAD_W-1:0]    sat;
  always_comb begin
    lo_sum = (PW+1)'(prod) + (PW+1)'($signed({1'b0, hi_q[7:0], 16'b0}));
    sv     = (PW+1)'(hi_q >>> 8) + (lo_sum >>> 24);
    if (sv[PW:GRAD_W-1] != {(PW-GRAD_W+2){sv[PW]}}) begin
      sat = sv[PW] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    end else begin
      sat = sv[GRAD_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      dxf_q <= $signed({s_axis_tdata[QX_LO+COORD_W-1], s_axis_tdata[QX_LO +: COORD_W]}) -
               $signed({left_q[CFG_W-1], left_q});
      dyf_q <= $signed({top_q[CFG_W-1], top_q}) -
               $signed({s_axis_tdata[QY_LO+COORD_W-1], s_axis_tdata[QY_LO +: COORD_W]});
    end
    // low pitch product is taken from the multiplier in the state after it is issued
    case (state_q)
      ST_MX1, ST_MY1: plo_q <= PW'(prod[PW-1:FRAC]);
      default: ;
    endcase
    case (state_q)
      ST_MY0, ST_MD0: sum_q <= prod + plo_q;
      default: ;
    endcase
    if (state_q == ST_MY1) fx_q <= map_coord;
    if (state_q == ST_MD1) fy_q <= map_coord;
    if (state_q == ST_RD && cnt_q != 3'd0) smp_q[cnt_q[1:0] - 2'd1] <= rdata_q;
    if (state_q == ST_CF) begin
      ca_q   <= sn - sp;
      cb_q   <= (sp <<< 1) - (sc <<< 2) - sc + (sn <<< 2) - sa;
      cb2_q  <= (sp <<< 2) - (sc <<< 3) - (sc <<< 1) + (sn <<< 3) - (sa <<< 1);
      cx_q   <= co_c;
      cc3_q  <= co_c + (co_c <<< 1);
      cmid_q <= sc;
    end
    case (state_q)
      ST_C2: accv_q <= OPW'((prod >>> FRAC) + PW'(cb_q));
      ST_C3: accd_q <= OPW'((prod >>> FRAC) + PW'(cb2_q));
      ST_C4: accv_q <= OPW'((prod >>> FRAC) + PW'(ca_q));
      default: ;
    endcase
    if (state_q == ST_C5) begin
      if (pass_q == PASS_ROW) rd_q[row_q] <= OPW'(res_d);
      if (pass_q == PASS_GY)  gy_q <= OPW'(-res_d);
    end
    if (state_q == ST_C6) begin
      if (pass_q == PASS_ROW) rv_q[row_q] <= OPW'(res_v);
      if (pass_q == PASS_GX)  gx_q <= OPW'(res_v);
    end
    if (state_q == ST_G1 || state_q == ST_G3) hi_q <= prod;
    if (state_q == ST_G2) ox_q <= sat;
    if (state_q == ST_G4 && out_free) odata_q <= {sat, ox_q};
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      row_q    <= '0;
      pass_q   <= PASS_ROW;
      ovalid_q <= 1'b0;
    end else begin
      // a new result replaces one that leaves in the same cycle
      if (state_q == ST_G4 && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_fire) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire && s_axis_tuser == OP_QUERY) state_q <= ST_MX0;
        end
        ST_MX0: state_q <= ST_MX1;
        ST_MX1: state_q <= ST_MY0;
        ST_MY0: state_q <= ST_MY1;
        ST_MY1: state_q <= ST_MD0;
        ST_MD0: state_q <= ST_MD1;
        ST_MD1: begin
          state_q <= ST_RD;
          cnt_q   <= '0;
          row_q   <= '0;
          pass_q  <= PASS_ROW;
        end
        ST_RD: begin
          // four reads issued, the last one lands in the next cycle
          if (cnt_q == 3'd4) begin
            state_q <= ST_CF;
          end
          cnt_q <= cnt_q + 3'd1;
        end
        ST_CF: state_q <= ST_C1;
        ST_C1: state_q <= ST_C2;
        ST_C2: state_q <= ST_C3;
        ST_C3: state_q <= ST_C4;
        ST_C4: state_q <= ST_C5;
        ST_C5: begin
          // y derivative needs no value step
          state_q <= (pass_q == PASS_GY) ? ST_G0 : ST_C6;
        end
        ST_C6: begin
          if (pass_q == PASS_ROW && row_q != 2'd3) begin
            row_q   <= row_q + 2'd1;
            cnt_q   <= '0;
            state_q <= ST_RD;
          end else begin
            pass_q  <= (pass_q == PASS_ROW) ? PASS_GX : PASS_GY;
            state_q <= ST_CF;
          end
        end
        ST_G0: state_q <= ST_G1;
        ST_G1: state_q <= ST_G2;
        ST_G2: state_q <= ST_G3;
        ST_G3: state_q <= ST_G4;
        ST_G4: begin
          // wait for the output register to drain
          if (out_free) begin
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `BIG_ASSERT(a_query_starts, (s_fire && s_axis_tuser == OP_QUERY) |=> (state_q == ST_MX0), "query did not start mapping")
  `BIG_ASSERT(a_coord_in_image, (state_q == ST_RD) |-> (xi <= wlim && yi <= hlim), "mapped point outside image")
  `BIG_ASSERT(a_read_in_store, (state_q == ST_RD) |-> (32'(rd_addr) < 32'(DEPTH)), "stencil read beyond store")
  `BIG_ASSERT(a_result_held, (state_q == ST_G4 && ovalid_q && !m_axis_tready) |=> (state_q == ST_G4 && ovalid_q), "result dropped while output busy")
  `BIG_ASSERT_NEVER(a_read_count, state_q == ST_RD && cnt_q > 3'd4, "stencil read count overrun")

endmodule
